FILE: hw/rtl/gml_pkg.sv
// Shared types and constants of the grid local maximum finder.
package gml_pkg;

  // Largest grid that the line stores, flags and position counters are sized for.
  localparam int COLS_MAX = 64;
  localparam int ROWS_MAX = 1024;

  // Configuration register field widths and register indexes.
  localparam int GRID_ROWS_W = 11;
  localparam int GRID_COLS_W = 7;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_GRID_ROWS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_COLS = 1'd1;

  // Three line stores rotate through the incoming, centre and above roles.
  localparam int NUM_BANKS = 3;
  localparam int BANK_W    = 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_SWEEP_RD,
    S_SWEEP_CHK,
    S_SWEEP_END
  } gml_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_ready;
    logic advance;
    logic push_center;
    logic park_center;
    logic sweep_step;
    logic sweep_take;
    logic push_final;
    logic clear_flags;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_xfer;
    logic center_hit;
    logic end_of_row;
    logic last_row;
    logic flag_hit;
    logic sweep_last;
    logic pending_valid;
    logic out_free;
  } dp_status_t;

endpackage

FILE: hw/rtl/gml_if.sv
// Stream interfaces for the pixel input and the maximum result output.
interface gml_pixel_if #(
  parameter int VALUE_WIDTH = 32
) ();
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink (input valid, input pixel_value, output ready);
endinterface

interface gml_max_if #(
  parameter int VALUE_WIDTH = 32
) ();
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] max_value;
  logic                          last_in_run;

  modport source (output valid, output max_value, output last_in_run, input ready);
  modport sink (input valid, input max_value, input last_in_run, output ready);
endinterface

FILE: hw/rtl/grid_local_maximum_finder.sv
// Grid local maximum finder: takes grid values in raster order and reports, in raster
// order, every value strictly greater than each of its existing up, down, left and right
// neighbours. A pixel is transferred while the two line stores are read, then compared
// and committed; a full output register holds the commit. A cell in any row but the
// last is reported while the pixel below it is evaluated, but the cell above the final
// pixel is parked and sent in the sweep. The final pixel of the grid is followed by a
// sweep over the last-row flags, a read and a check step per column and one closing
// step, during which no further pixel is taken; output stalls stretch the sweep.
// The registered read sets these steps; the sweep reads the last row from its store.
// Configuration may only be written while no grid result is outstanding.
module grid_local_maximum_finder import gml_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  gml_pixel_if.sink              pixel_in,
  gml_max_if.source              max_out
);

  dp_cmd_t    cmd;
  dp_status_t st;

  // Controller.
  gml_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  // Datapath.
  gml_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel_in  (pixel_in),
    .max_out   (max_out),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

FILE: hw/rtl/gml_ram.sv
// Generic single write port, single read port RAM with registered read data.
module gml_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/gml_ctrl.sv
// Controller state machine: pixel evaluation and the last-row flag sweep.
module gml_ctrl import gml_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  gml_state_t state;
  gml_state_t state_next;

  logic eval_flush;
  logic eval_blocked;
  logic chk_blocked;
  logic end_blocked;

  assign eval_flush   = st.end_of_row && st.last_row;
  assign eval_blocked = st.center_hit && !st.out_free;
  assign chk_blocked  = st.flag_hit && st.pending_valid && !st.out_free;
  assign end_blocked  = st.pending_valid && !st.out_free;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (st.in_xfer) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (eval_flush) begin
          state_next = S_SWEEP_RD;
        end else if (!eval_blocked) begin
          state_next = S_IDLE;
        end
      end
      S_SWEEP_RD: begin
        state_next = S_SWEEP_CHK;
      end
      S_SWEEP_CHK: begin
        if (!chk_blocked) begin
          state_next = st.sweep_last ? S_SWEEP_END : S_SWEEP_RD;
        end
      end
      S_SWEEP_END: begin
        if (!end_blocked) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
      end
      S_EVAL: begin
        if (eval_flush) begin
          cmd.advance     = 1'b1;
          cmd.park_center = 1'b1;
        end else if (!eval_blocked) begin
          cmd.advance     = 1'b1;
          cmd.push_center = st.center_hit;
        end
      end
      S_SWEEP_RD: begin
        cmd = '0;
      end
      S_SWEEP_CHK: begin
        if (!chk_blocked) begin
          cmd.sweep_take = st.flag_hit;
          cmd.sweep_step = !st.sweep_last;
        end
      end
      S_SWEEP_END: begin
        if (!end_blocked) begin
          cmd.push_final  = st.pending_valid;
          cmd.clear_flags = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

  // A parked result only exists while the sweep runs.
  a_no_pending_when_ready: assert property (@(posedge clk) disable iff (rst)
    cmd.in_ready |-> !st.pending_valid)
    else $error("pending result held while accepting pixels");

  // Results are only pushed into a free output register.
  a_push_into_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.push_center || cmd.push_final) |-> st.out_free)
    else $error("result pushed into a full output register");

  // After a pixel transfer the controller evaluates it.
  a_xfer_then_eval: assert property (@(posedge clk) disable iff (rst)
    st.in_xfer |=> (state == S_EVAL))
    else $error("accepted pixel not evaluated");

endmodule

FILE: hw/rtl/gml_datapath.sv
// Datapath: configuration, line stores, neighbour window, compares, flags and output stage.
module gml_datapath import gml_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  gml_pixel_if.sink              pixel_in,
  gml_max_if.source              max_out,
  input  dp_cmd_t                cmd,
  output dp_status_t             st
);

  localparam int COL_W = $clog2(COLS_MAX);
  localparam int ROW_W = $clog2(ROWS_MAX);

  // Configuration registers.
  logic [GRID_ROWS_W-1:0] grid_rows;
  logic [GRID_COLS_W-1:0] grid_cols;
  logic [GRID_ROWS_W-1:0] rows_wr;
  logic [GRID_COLS_W-1:0] cols_wr;

  // Position and bank roles.
  logic [ROW_W-1:0]  row_index;
  logic [COL_W-1:0]  col_index;
  logic [BANK_W-1:0] in_bank;
  logic [BANK_W-1:0] ctr_bank;
  logic [BANK_W-1:0] abv_bank;

  // Neighbour window.
  logic signed [VALUE_WIDTH-1:0] pix;
  logic signed [VALUE_WIDTH-1:0] cur_c;
  logic signed [VALUE_WIDTH-1:0] prev_c;
  logic signed [VALUE_WIDTH-1:0] prev_in;
  logic signed [VALUE_WIDTH-1:0] prev2_in;
  logic signed [VALUE_WIDTH-1:0] first_in;
  logic signed [VALUE_WIDTH-1:0] nxt_c;
  logic signed [VALUE_WIDTH-1:0] abv_c;
  logic signed [VALUE_WIDTH-1:0] sweep_data;

  // Last-row flags and the sweep.
  logic [COLS_MAX-1:0] flags;
  logic [COLS_MAX-1:0] flags_next;
  logic [COL_W-1:0]    sweep_idx;

  // Parked result and output register.
  logic                          pend_valid;
  logic signed [VALUE_WIDTH-1:0] pend_value;
  logic                          out_valid;
  logic signed [VALUE_WIDTH-1:0] out_value;
  logic                          out_last;
  logic                          out_free;
  logic                          out_load;
  logic                          sweep_push;

  logic             in_xfer;
  logic             last_row;
  logic             end_of_row;
  logic             right_ok;
  logic             col_lt_cols;
  logic             center_hit;
  logic             flag_prev_hit;
  logic             flag_cur_hit;
  logic [COL_W-1:0] col_next_addr;

  logic [VALUE_WIDTH-1:0] rd_data [NUM_BANKS];

  // Saturate written register values into their legal ranges.
  always_comb begin
    rows_wr = cfg_data[GRID_ROWS_W-1:0];
    if (int'(rows_wr) < 2) begin
      rows_wr = GRID_ROWS_W'(2);
    end else if (int'(rows_wr) > ROWS_MAX) begin
      rows_wr = GRID_ROWS_W'(ROWS_MAX);
    end
    cols_wr = cfg_data[GRID_COLS_W-1:0];
    if (int'(cols_wr) < 2) begin
      cols_wr = GRID_COLS_W'(2);
    end else if (int'(cols_wr) > COLS_MAX) begin
      cols_wr = GRID_COLS_W'(COLS_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= GRID_ROWS_W'(2);
      grid_cols <= GRID_COLS_W'(2);
    end else if (cfg_we) begin
      if (cfg_index == REG_GRID_ROWS) begin
        grid_rows <= rows_wr;
      end else if (cfg_index == REG_GRID_COLS) begin
        grid_cols <= cols_wr;
      end
    end
  end

  // Input handshake.
  assign pixel_in.ready = cmd.in_ready;
  assign in_xfer        = pixel_in.valid && pixel_in.ready;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pix <= pixel_in.pixel_value;
    end
  end

  // Line stores: the centre bank reads one column ahead, the above bank reads
  // the current column and the incoming bank is read by the flag sweep.
  assign col_next_addr = col_index + COL_W'(1);

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic [COL_W-1:0] raddr;

    assign raddr = (BANK_W'(b) == ctr_bank) ? col_next_addr :
                   (BANK_W'(b) == abv_bank) ? col_index : sweep_idx;

    gml_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (COLS_MAX)
    ) u_line (
      .clk   (clk),
      .we    (in_xfer && (BANK_W'(b) == in_bank)),
      .waddr (col_index),
      .wdata (pixel_in.pixel_value),
      .raddr (raddr),
      .rdata (rd_data[b])
    );
  end

  assign nxt_c      = $signed(rd_data[ctr_bank]);
  assign abv_c      = $signed(rd_data[abv_bank]);
  assign sweep_data = $signed(rd_data[in_bank]);

  // Position decode.
  assign last_row    = int'(row_index) + 1 >= int'(grid_rows);
  assign end_of_row  = int'(col_index) + 1 >= int'(grid_cols);
  assign right_ok    = (int'(col_index) + 1 < int'(grid_cols)) &&
                       (int'(col_index) + 1 < COLS_MAX);
  assign col_lt_cols = int'(col_index) < int'(grid_cols);

  // Centre cell verdict, decided now that the cell below has arrived.
  assign center_hit = (row_index != '0) && (cur_c > pix) &&
                      ((col_index == '0) || (cur_c > prev_c)) &&
                      (!right_ok || (cur_c > nxt_c)) &&
                      ((int'(row_index) <= 1) || (cur_c > abv_c));

  // Last-row verdicts for the previous column and, at row end, the current one.
  assign flag_prev_hit = (prev_in > prev_c) &&
                         ((int'(col_index) <= 1) || (prev_in > prev2_in)) &&
                         (!col_lt_cols || (prev_in > pix));
  assign flag_cur_hit  = (pix > cur_c) && ((col_index == '0) || (pix > prev_in));

  always_comb begin
    flags_next = flags;
    if (cmd.clear_flags) begin
      flags_next = '0;
    end else if (cmd.advance && last_row) begin
      if (col_index != '0) begin
        flags_next[col_index - COL_W'(1)] = flag_prev_hit;
      end
      if (end_of_row) begin
        flags_next[col_index] = flag_cur_hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else begin
      flags <= flags_next;
    end
  end

  // Position and bank rotation at the end of each pixel.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_index <= '0;
      col_index <= '0;
      in_bank   <= BANK_W'(0);
      ctr_bank  <= BANK_W'(1);
      abv_bank  <= BANK_W'(2);
    end else if (cmd.advance) begin
      if (end_of_row) begin
        col_index <= '0;
        if (last_row) begin
          row_index <= '0;
        end else begin
          row_index <= row_index + ROW_W'(1);
          abv_bank  <= ctr_bank;
          ctr_bank  <= in_bank;
          in_bank   <= abv_bank;
        end
      end else begin
        col_index <= col_index + COL_W'(1);
      end
    end
  end

  // Sliding window over the centre and incoming rows.
  always_ff @(posedge clk) begin
    if (cmd.advance) begin
      prev2_in <= prev_in;
      prev_in  <= pix;
      if (col_index == '0) begin
        first_in <= pix;
      end
      if (end_of_row) begin
        cur_c <= (col_index == '0) ? pix : first_in;
      end else begin
        prev_c <= cur_c;
        cur_c  <= nxt_c;
      end
    end
  end

  // Sweep index over the last-row flags.
  always_ff @(posedge clk) begin
    if (cmd.park_center) begin
      sweep_idx <= '0;
    end else if (cmd.sweep_step) begin
      sweep_idx <= sweep_idx + COL_W'(1);
    end
  end

  // The parked result is sent one step late so that the final one is marked.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.park_center) begin
      pend_valid <= center_hit;
    end else if (cmd.sweep_take) begin
      pend_valid <= 1'b1;
    end else if (cmd.push_final) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.park_center) begin
      pend_value <= cur_c;
    end else if (cmd.sweep_take) begin
      pend_value <= sweep_data;
    end
  end

  // Output register.
  assign out_free   = !out_valid || max_out.ready;
  assign sweep_push = cmd.sweep_take && pend_valid;
  assign out_load   = cmd.push_center || sweep_push || cmd.push_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (max_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_center) begin
      out_value <= cur_c;
      out_last  <= 1'b1;
    end else if (sweep_push) begin
      out_value <= pend_value;
      out_last  <= 1'b0;
    end else if (cmd.push_final) begin
      out_value <= pend_value;
      out_last  <= 1'b1;
    end
  end

  assign max_out.valid       = out_valid;
  assign max_out.max_value   = out_value;
  assign max_out.last_in_run = out_last;

  // Status to the controller.
  always_comb begin
    st               = '0;
    st.in_xfer       = in_xfer;
    st.center_hit    = center_hit;
    st.end_of_row    = end_of_row;
    st.last_row      = last_row;
    st.flag_hit      = flags[sweep_idx];
    st.sweep_last    = (int'(sweep_idx) + 1 >= int'(grid_cols)) ||
                       (int'(sweep_idx) == COLS_MAX - 1);
    st.pending_valid = pend_valid;
    st.out_free      = out_free;
  end

  // The three line stores always hold three different roles.
  a_banks_distinct: assert property (@(posedge clk) disable iff (rst)
    (in_bank != ctr_bank) && (ctr_bank != abv_bank) && (in_bank != abv_bank))
    else $error("line store roles overlap");

  // A new grid starts with every last-row flag cleared.
  a_flags_clear_new_grid: assert property (@(posedge clk) disable iff (rst)
    (pixel_in.ready && (row_index == '0)) |-> (flags == '0))
    else $error("last-row flags left over at the start of a grid");

  // A parked result moves on only into a free output register.
  a_sweep_push_free: assert property (@(posedge clk) disable iff (rst)
    sweep_push |-> out_free)
    else $error("parked result pushed into a full output register");

endmodule

FILE: test/grid_local_maximum_finder_test.sv
// Self-checking testbench of the grid local maximum finder.
`timescale 1ns / 100ps

module grid_local_maximum_finder_test import gml_pkg::*; ();

  localparam int VALUE_WIDTH   = 32;
  // Longest quiet spell of the block: the last-row sweep plus some margin.
  localparam int SETTLE_CYCLES = 2 * COLS_MAX + 16;
  localparam int LONG_HOLD     = 600;
  localparam int PHASE_ITEMS   = 50;
  localparam int REPORT_LIMIT  = 10;

  typedef logic signed [VALUE_WIDTH-1:0] pix_t;

  localparam pix_t PIX_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam pix_t PIX_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  typedef struct packed {
    pix_t value;
    logic last;
  } peak_t;

  typedef enum int {
    FILL_WIDE,
    FILL_NARROW,
    FILL_CHECKER,
    FILL_EXTREME
  } fill_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  gml_pixel_if #(.VALUE_WIDTH(VALUE_WIDTH)) pixel_bus ();
  gml_max_if #(.VALUE_WIDTH(VALUE_WIDTH)) max_bus ();

  grid_local_maximum_finder #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel_in  (pixel_bus),
    .max_out   (max_bus)
  );

  // Own copy of the line stores, flags, position and grid size.
  pix_t        above_line [COLS_MAX];
  pix_t        centre_line[COLS_MAX];
  pix_t        new_line   [COLS_MAX];
  bit          bottom_flag[COLS_MAX];
  int unsigned cur_row;
  int unsigned cur_col;
  int unsigned rows_cfg;
  int unsigned cols_cfg;

  peak_t pending_peaks[$];

  int   error_count;
  int   pixels_sent;
  int   peaks_seen;
  int   grids_sent;
  int   send_gap_pct;
  int   recv_stall_pct;
  int   hold_left;
  logic hold_start;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  initial begin
    #10_000_000;
    $display("** grid_local_maximum_finder: FAILED **");
    $finish;
  end

  task automatic note_error(input string what);
    error_count++;
    if (error_count <= REPORT_LIMIT) $display("ERROR at %0t: %s", $realtime, what);
  endtask

  function automatic void reset_predictor();
    foreach (above_line[k]) begin
      above_line[k]  = '0;
      centre_line[k] = '0;
      new_line[k]    = '0;
      bottom_flag[k] = 1'b0;
    end
    cur_row  = 0;
    cur_col  = 0;
    rows_cfg = 2;
    cols_cfg = 2;
  endfunction

  // Register writes saturate into the legal range of each size.
  function automatic void apply_register(input logic [CFG_INDEX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    int unsigned v;
    if (idx == REG_GRID_ROWS) begin
      v = data[GRID_ROWS_W-1:0];
      rows_cfg = (v < 2) ? 2 : (v > ROWS_MAX) ? ROWS_MAX : v;
    end else if (idx == REG_GRID_COLS) begin
      v = data[GRID_COLS_W-1:0];
      cols_cfg = (v < 2) ? 2 : (v > COLS_MAX) ? COLS_MAX : v;
    end
  endfunction

  // A centre-row cell against the pixel below, its row neighbours and the cell above.
  function automatic bit centre_peak(input int unsigned j, input bit has_above,
                                     input pix_t below);
    pix_t v;
    bit   ok;
    v  = centre_line[j];
    ok = v > below;
    if (j > 0) ok = ok && (v > centre_line[j-1]);
    if (j + 1 < cols_cfg) ok = ok && (v > centre_line[j+1]);
    if (has_above) ok = ok && (v > above_line[j]);
    return ok;
  endfunction

  // A last-row cell against the cell above and its row neighbours.
  function automatic bit bottom_peak(input int unsigned j);
    pix_t v;
    bit   ok;
    v  = new_line[j];
    ok = v > centre_line[j];
    if (j > 0) ok = ok && (v > new_line[j-1]);
    if (j + 1 < cols_cfg) ok = ok && (v > new_line[j+1]);
    return ok;
  endfunction

  // Works out the maxima that one accepted pixel releases and queues them in order.
  function automatic void locate_peaks(input pix_t x);
    int unsigned j;
    bit          bottom_row;
    bit          row_done;
    peak_t       run[$];
    j          = cur_col;
    bottom_row = (cur_row + 1 >= rows_cfg);
    row_done   = (j + 1 >= cols_cfg);
    new_line[j] = x;
    if (cur_row > 0 && centre_peak(j, cur_row > 1, x))
      run.push_back('{value: centre_line[j], last: 1'b0});
    if (bottom_row && j > 0) bottom_flag[j-1] = bottom_peak(j - 1);
    if (row_done) begin
      if (bottom_row) begin
        bottom_flag[j] = bottom_peak(j);
        for (int k = 0; k < cols_cfg; k++) begin
          if (bottom_flag[k]) run.push_back('{value: new_line[k], last: 1'b0});
        end
        foreach (bottom_flag[k]) bottom_flag[k] = 1'b0;
        cur_row = 0;
      end else begin
        above_line  = centre_line;
        centre_line = new_line;
        cur_row++;
      end
      cur_col = 0;
    end else begin
      cur_col = j + 1;
    end
    if (run.size() != 0) run[run.size()-1].last = 1'b1;
    foreach (run[k]) pending_peaks.push_back(run[k]);
  endfunction

  // Offers one pixel after a random gap and holds it until the transfer.
  task automatic push_pixel(input pix_t v);
    while ($urandom_range(99) < send_gap_pct) begin
      pixel_bus.valid <= 1'b0;
      @(posedge clk);
    end
    pixel_bus.valid       <= 1'b1;
    pixel_bus.pixel_value <= v;
    @(posedge clk);
    while (!pixel_bus.ready) @(posedge clk);
    locate_peaks(v);
    pixels_sent++;
  endtask

  // Writes both size registers, rows first and then columns.
  task automatic write_grid_size(input logic [CFG_DATA_W-1:0] rows_word,
                                 input logic [CFG_DATA_W-1:0] cols_word);
    cfg_we    <= 1'b1;
    cfg_index <= REG_GRID_ROWS;
    cfg_data  <= rows_word;
    @(posedge clk);
    apply_register(REG_GRID_ROWS, rows_word);
    cfg_index <= REG_GRID_COLS;
    cfg_data  <= cols_word;
    @(posedge clk);
    apply_register(REG_GRID_COLS, cols_word);
    cfg_we <= 1'b0;
  endtask

  // Waits for every expected maximum, then for the block to go quiet.
  task automatic wait_drained();
    pixel_bus.valid <= 1'b0;
    while (pending_peaks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic pix_t cell_value(input fill_t fill, input int i, input int j,
                                      input pix_t hi, input pix_t lo, input bit odd_high);
    case (fill)
      FILL_WIDE:    return pix_t'($urandom);
      FILL_NARROW:  return pix_t'(int'($urandom_range(4)) - 2);
      FILL_CHECKER: return ((((i + j) % 2) == 1) == odd_high) ? hi : lo;
      default: begin
        case ($urandom_range(6))
          0:       return PIX_MIN;
          1:       return PIX_MIN + 1;
          2:       return -1;
          3:       return 0;
          4:       return 1;
          5:       return PIX_MAX - 1;
          default: return PIX_MAX;
        endcase
      end
    endcase
  endfunction

  task automatic send_grid(input int rows, input int cols, input fill_t fill,
                           input bit odd_high);
    pix_t a;
    pix_t b;
    pix_t hi;
    pix_t lo;
    a  = pix_t'($urandom);
    b  = pix_t'($urandom);
    hi = (a > b) ? a : b;
    lo = (a > b) ? b : a;
    if (hi == lo) begin
      hi = PIX_MAX;
      lo = PIX_MIN;
    end
    for (int i = 0; i < rows; i++) begin
      for (int j = 0; j < cols; j++) push_pixel(cell_value(fill, i, j, hi, lo, odd_high));
    end
    grids_sent++;
  endtask

  // Register words that saturate to the wanted size, with ignored upper bits on the column word.
  function automatic logic [CFG_DATA_W-1:0] rows_word(input int rows);
    if (rows == 2 && $urandom_range(1) == 1) return CFG_DATA_W'($urandom_range(1));
    return CFG_DATA_W'(rows);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] cols_word(input int cols);
    logic [GRID_COLS_W-1:0] base;
    logic [CFG_DATA_W-1:0]  word;
    base = GRID_COLS_W'(cols);
    if (cols == COLS_MAX && $urandom_range(1) == 1)
      base = GRID_COLS_W'($urandom_range(127, COLS_MAX + 1));
    else if (cols == 2 && $urandom_range(1) == 1)
      base = GRID_COLS_W'($urandom_range(1));
    word = CFG_DATA_W'($urandom);
    word[GRID_COLS_W-1:0] = base;
    return word;
  endfunction

  // Receiver: random stalls, or a long hold-off counted here once requested.
  initial begin
    max_bus.ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst) begin
        max_bus.ready <= 1'b0;
      end else if (hold_start && hold_left == 0) begin
        hold_left = LONG_HOLD;
        max_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left = hold_left - 1;
        max_bus.ready <= 1'b0;
      end else begin
        max_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Each result transfer is compared with the oldest expected maximum.
  always @(posedge clk) begin
    peak_t want;
    if (!rst && max_bus.valid && max_bus.ready) begin
      peaks_seen++;
      if (pending_peaks.size() == 0) begin
        note_error($sformatf("unexpected maximum %0d last=%0b",
                             max_bus.max_value, max_bus.last_in_run));
      end else begin
        want = pending_peaks.pop_front();
        if (max_bus.max_value !== want.value || max_bus.last_in_run !== want.last)
          note_error($sformatf("maximum expected %0d last=%0b, got %0d last=%0b",
                               want.value, want.last, max_bus.max_value,
                               max_bus.last_in_run));
      end
    end
  end

  // The reset size of two by two, with both extreme values.
  task automatic test_reset_values();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    push_pixel(PIX_MAX);
    push_pixel(PIX_MIN);
    push_pixel(PIX_MIN);
    push_pixel(PIX_MAX);
    wait_drained();
  endtask

  // Equal neighbours: a flat grid has no strict maximum.
  task automatic test_plateau();
    repeat (4) push_pixel(-1);
    wait_drained();
  endtask

  // Three by three: corners, edges and a centre cell, with a tie on the last row.
  task automatic test_three_by_three();
    write_grid_size(CFG_DATA_W'(3), CFG_DATA_W'(3));
    push_pixel(-1);
    push_pixel(PIX_MIN);
    push_pixel(1);
    push_pixel(PIX_MIN);
    push_pixel(PIX_MAX);
    push_pixel(PIX_MIN + 1);
    push_pixel(0);
    push_pixel(PIX_MAX - 1);
    push_pixel(PIX_MAX - 1);
    wait_drained();
  endtask

  // Sizes written below the legal range fall back to two.
  task automatic test_low_saturation();
    write_grid_size(CFG_DATA_W'(1), CFG_DATA_W'(0));
    push_pixel(1);
    push_pixel(0);
    push_pixel(-2);
    push_pixel(3);
    wait_drained();
  endtask

  // Random small grids, some of them back to back.
  task automatic test_random_grids(input int gap_pct, input int stall_pct, input int items);
    int    start;
    int    rows;
    int    cols;
    int    reps;
    fill_t fill;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    start = pixels_sent;
    while (pixels_sent - start < items) begin
      rows = $urandom_range(6, 2);
      cols = $urandom_range(12, 2);
      write_grid_size(rows_word(rows), cols_word(cols));
      reps = $urandom_range(2, 1);
      repeat (reps) begin
        fill = fill_t'($urandom_range(3));
        send_grid(rows, cols, fill, 1'($urandom_range(1)));
      end
      wait_drained();
    end
  endtask

  // The receiver holds off while a grid streams in, so the input stalls.
  task automatic test_back_pressure();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    write_grid_size(CFG_DATA_W'(3), CFG_DATA_W'(16));
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    send_grid(3, 16, FILL_CHECKER, 1'b0);
    wait_drained();
  endtask

  // A checkerboard that releases the largest run on the final pixel.
  task automatic test_longest_run();
    send_gap_pct   = 38;
    recv_stall_pct = 38;
    write_grid_size(CFG_DATA_W'(2), CFG_DATA_W'(127));
    send_grid(2, COLS_MAX, FILL_CHECKER, 1'b1);
    wait_drained();
  endtask

  initial begin
    rst                   <= 1'b1;
    cfg_we                <= 1'b0;
    cfg_index             <= '0;
    cfg_data              <= '0;
    pixel_bus.valid       <= 1'b0;
    pixel_bus.pixel_value <= '0;
    hold_start            <= 1'b0;
    error_count    = 0;
    pixels_sent    = 0;
    peaks_seen     = 0;
    grids_sent     = 0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    reset_predictor();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_plateau();
    test_three_by_three();
    test_low_saturation();
    test_random_grids(0, 0, PHASE_ITEMS);
    test_random_grids(49, 0, PHASE_ITEMS);
    test_random_grids(0, 49, PHASE_ITEMS);
    test_random_grids(38, 38, PHASE_ITEMS);
    test_back_pressure();
    test_longest_run();

    if (pending_peaks.size() != 0)
      note_error($sformatf("%0d expected maxima never arrived", pending_peaks.size()));
    $display("Sent %0d pixels in %0d grids and checked %0d maxima, %0d errors.",
             pixels_sent, grids_sent, peaks_seen, error_count);
    $display("Covered saturated sizes, the widest grid, idling mixes and a long hold-off.");
    if (error_count == 0) begin
      $display("** grid_local_maximum_finder: PASSED **");
    end else begin
      $display("** grid_local_maximum_finder: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/gml_pkg.sv
hw/rtl/gml_if.sv
hw/rtl/gml_ram.sv
hw/rtl/gml_ctrl.sv
hw/rtl/gml_datapath.sv
hw/rtl/grid_local_maximum_finder.sv
test/grid_local_maximum_finder_test.sv
